// File: sv/ddws_pkg.sv
// ----------------------------------------------------------------------------
// ddws_pkg - shared types and arithmetic for the wheel speed PI unit
// Fixed-point formats, sequencer states, register indexes and saturation
// helpers used by the controller and its shared multiplier.
// ----------------------------------------------------------------------------
package ddws_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int COUNT_BITS = 13;
    localparam int MEAS_SHIFT = 20 - FRAC_BITS;

    localparam int SPEED_W = 16;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int OPA_W   = ERR_W + 1;
    localparam int OPB_W   = 16;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int LIMIT_W = 15;
    localparam int LIM_W   = LIMIT_W + FRAC_BITS;
    localparam int ACC_W   = LIM_W + 1;
    localparam int SUM_W   = PROD_W + 2;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_PER_COUNT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LEFT       = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RIGHT      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT      = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT     = CFG_IDX_W'(7);

    localparam logic [1:0] MODE_KIN  = 2'd1;
    localparam logic [1:0] MODE_TURN = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAS_L,
        ST_MEAS_R,
        ST_TURN,
        ST_TARGET,
        ST_L_ISTEP,
        ST_L_PTERM,
        ST_L_ACC,
        ST_R_PTERM,
        ST_R_ACC,
        ST_OUT
    } state_t;

    // operands for the shared multiplier: signed a times unsigned b
    typedef struct packed {
        logic signed [OPA_W-1:0] a;
        logic        [OPB_W-1:0] b;
    } mul_req_t;

    function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(32767);
        lo = -PROD_W'(32768);
        if (v > hi)
            return 16'sh7fff;
        else if (v < lo)
            return 16'sh8000;
        else
            return v[SPEED_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp_lim(input logic signed [SUM_W-1:0] v,
                                                          input logic [LIM_W-1:0] lim);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (v > hi)
            return hi[ACC_W-1:0];
        else if (v < lo)
            return lo[ACC_W-1:0];
        else
            return v[ACC_W-1:0];
    endfunction

    // accumulator to drive, truncating toward zero
    function automatic logic signed [SPEED_W-1:0] drive_of(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] t;
        t = (acc < 0) ? ((ACC_W+1)'(acc) + (ACC_W+1)'((1 << FRAC_BITS) - 1))
                      : (ACC_W+1)'(acc);
        t = t >>> FRAC_BITS;
        return t[SPEED_W-1:0];
    endfunction

endpackage

// File: sv/ddws_mul.sv
// ----------------------------------------------------------------------------
// ddws_mul - shared signed by unsigned multiplier
// One product per cycle, registered; result valid the cycle after issue.
// ----------------------------------------------------------------------------
module ddws_mul (
    input  logic                                   clk,
    input  ddws_pkg::mul_req_t                     req,
    output logic signed [ddws_pkg::PROD_W-1:0]     prod
);

    logic signed [ddws_pkg::PROD_W:0]   full;
    logic signed [ddws_pkg::PROD_W-1:0] prod_reg;
    logic signed [ddws_pkg::PROD_W-1:0] prod_next;

    assign full = (ddws_pkg::PROD_W+1)'(req.a)
                * $signed({{(ddws_pkg::PROD_W+1-ddws_pkg::OPB_W){1'b0}}, req.b});
    assign prod_next = full[ddws_pkg::PROD_W-1:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: sv/diff_drive_wheel_speed_pi_unit.sv
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_pi_unit - two-wheel incremental PI speed controller
// Modes 1 and 2 measure, set targets and run both PI updates; a stop word goes
// straight to output. A new word is taken only in idle. One shared multiplier is
// reused for both speed measurements, the turn term and the four PI products.
// Reset: rst_n async low; registers to defaults, errors and accumulators zero.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_pi_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left_count[12:0], right_count[25:13],
                                   // forward_speed[41:26], turn_rate[57:42], zero
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // output word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_drive[15:0], right_drive[31:16]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SW = ddws_pkg::SPEED_W;
    localparam int EW = ddws_pkg::ERR_W;
    localparam int AW = ddws_pkg::OPA_W;
    localparam int PW = ddws_pkg::PROD_W;
    localparam int CW = ddws_pkg::COUNT_BITS;
    localparam int LW = ddws_pkg::LIMIT_W;
    localparam int FB = ddws_pkg::FRAC_BITS;
    localparam int XW = ddws_pkg::ACC_W;
    localparam int UW = ddws_pkg::SUM_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0]          prop_gain_reg;
    logic [15:0]          integ_gain_reg;
    logic [15:0]          spc_reg;
    logic [LW-1:0]        half_track_reg;
    logic signed [SW-1:0] turn_left_reg;
    logic signed [SW-1:0] turn_right_reg;
    logic [LW-1:0]        step_limit_reg;
    logic [LW-1:0]        drive_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= 16'd400;
            integ_gain_reg  <= 16'd300;
            spc_reg         <= 16'd54903;
            half_track_reg  <= LW'(328);
            turn_left_reg   <= 16'sd205;
            turn_right_reg  <= 16'sd1024;
            step_limit_reg  <= LW'(1000);
            drive_limit_reg <= LW'(6000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ddws_pkg::REG_PROP_GAIN:       prop_gain_reg   <= cfg_data;
                ddws_pkg::REG_INTEG_GAIN:      integ_gain_reg  <= cfg_data;
                ddws_pkg::REG_SPEED_PER_COUNT: spc_reg         <= cfg_data;
                ddws_pkg::REG_HALF_TRACK:      half_track_reg  <= cfg_data[LW-1:0];
                ddws_pkg::REG_TURN_LEFT:       turn_left_reg   <= $signed(cfg_data);
                ddws_pkg::REG_TURN_RIGHT:      turn_right_reg  <= $signed(cfg_data);
                ddws_pkg::REG_STEP_LIMIT:      step_limit_reg  <= cfg_data[LW-1:0];
                ddws_pkg::REG_DRIVE_LIMIT:     drive_limit_reg <= cfg_data[LW-1:0];
                default: ;  // indexes past the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    ddws_pkg::state_t state_reg, state_next;

    logic                 stop_reg, stop_next;
    logic                 kin_reg, kin_next;
    logic signed [CW-1:0] lc_reg, rc_reg;
    logic signed [SW-1:0] vx_reg, vz_reg;

    logic signed [SW-1:0] lm_reg, lm_next, rm_reg, rm_next;
    logic signed [SW-1:0] lt_reg, lt_next, rt_reg, rt_next;
    logic signed [XW-1:0] istep_reg, istep_next;

    logic signed [EW-1:0] l_prev_reg, l_prev_next, r_prev_reg, r_prev_next;
    logic signed [XW-1:0] l_acc_reg, l_acc_next, r_acc_reg, r_acc_next;

    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_data_reg, out_data_next;

    ddws_pkg::mul_req_t   mul_req;
    logic signed [PW-1:0] prod;

    ddws_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // operands derived from the captured word
    logic signed [AW-1:0] lc_ext, rc_ext, vz_ext, vz_eff;
    logic signed [EW-1:0] err_l, err_r;
    logic signed [PW-1:0] turn_t;
    logic signed [PW-1:0] vx_wide;
    logic [ddws_pkg::LIM_W-1:0] step_lim, drive_lim;
    logic                 in_stop;

    assign lc_ext   = AW'(lc_reg);
    assign rc_ext   = AW'(rc_reg);
    assign vz_ext   = AW'(vz_reg);
    assign vz_eff   = vx_reg[SW-1] ? -vz_ext : vz_ext;   // reversing flips the turn
    assign err_l    = EW'(lt_reg) - EW'(lm_reg);
    assign err_r    = EW'(rt_reg) - EW'(rm_reg);
    assign turn_t   = prod >>> FB;
    assign vx_wide  = PW'(vx_reg);
    assign step_lim  = {step_limit_reg, {FB{1'b0}}};
    assign drive_lim = {drive_limit_reg, {FB{1'b0}}};
    assign in_stop  = (s_tuser != ddws_pkg::MODE_KIN) && (s_tuser != ddws_pkg::MODE_TURN);

    assign s_tready = (state_reg == ddws_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        stop_next      = stop_reg;
        kin_next       = kin_reg;
        lm_next        = lm_reg;
        rm_next        = rm_reg;
        lt_next        = lt_reg;
        rt_next        = rt_reg;
        istep_next     = istep_reg;
        l_prev_next    = l_prev_reg;
        r_prev_next    = r_prev_reg;
        l_acc_next     = l_acc_reg;
        r_acc_next     = r_acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_req.a      = '0;
        mul_req.b      = '0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ddws_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    stop_next  = in_stop;
                    kin_next   = (s_tuser == ddws_pkg::MODE_KIN);
                    state_next = in_stop ? ddws_pkg::ST_OUT : ddws_pkg::ST_MEAS_L;
                end
            end
            ddws_pkg::ST_MEAS_L:
            begin
                mul_req.a  = -lc_ext;       // left encoder counts the other way
                mul_req.b  = spc_reg;
                state_next = ddws_pkg::ST_MEAS_R;
            end
            ddws_pkg::ST_MEAS_R:
            begin
                lm_next    = ddws_pkg::sat16(prod >>> ddws_pkg::MEAS_SHIFT);
                mul_req.a  = rc_ext;
                mul_req.b  = spc_reg;
                state_next = ddws_pkg::ST_TURN;
            end
            ddws_pkg::ST_TURN:
            begin
                rm_next    = ddws_pkg::sat16(prod >>> ddws_pkg::MEAS_SHIFT);
                mul_req.a  = vz_eff;
                mul_req.b  = {1'b0, half_track_reg};
                state_next = ddws_pkg::ST_TARGET;
            end
            ddws_pkg::ST_TARGET:
            begin
                if (kin_reg)
                begin
                    lt_next = ddws_pkg::sat16(vx_wide - turn_t);
                    rt_next = ddws_pkg::sat16(vx_wide + turn_t);
                end
                else
                begin
                    lt_next = turn_left_reg;
                    rt_next = turn_right_reg;
                end
                state_next = ddws_pkg::ST_L_ISTEP;
            end
            ddws_pkg::ST_L_ISTEP:
            begin
                mul_req.a  = AW'(err_l);
                mul_req.b  = integ_gain_reg;
                state_next = ddws_pkg::ST_L_PTERM;
            end
            ddws_pkg::ST_L_PTERM:
            begin
                istep_next = ddws_pkg::clamp_lim(UW'(prod), step_lim);
                mul_req.a  = AW'(err_l) - AW'(l_prev_reg);
                mul_req.b  = prop_gain_reg;
                state_next = ddws_pkg::ST_L_ACC;
            end
            ddws_pkg::ST_L_ACC:
            begin
                l_acc_next  = ddws_pkg::clamp_lim(UW'(l_acc_reg) + UW'(prod) + UW'(istep_reg),
                                                  drive_lim);
                l_prev_next = err_l;
                // right integral product overlaps the left update
                mul_req.a   = AW'(err_r);
                mul_req.b   = integ_gain_reg;
                state_next  = ddws_pkg::ST_R_PTERM;
            end
            ddws_pkg::ST_R_PTERM:
            begin
                istep_next = ddws_pkg::clamp_lim(UW'(prod), step_lim);
                mul_req.a  = AW'(err_r) - AW'(r_prev_reg);
                mul_req.b  = prop_gain_reg;
                state_next = ddws_pkg::ST_R_ACC;
            end
            ddws_pkg::ST_R_ACC:
            begin
                r_acc_next  = ddws_pkg::clamp_lim(UW'(r_acc_reg) + UW'(prod) + UW'(istep_reg),
                                                  drive_lim);
                r_prev_next = err_r;
                state_next  = ddws_pkg::ST_OUT;
            end
            ddws_pkg::ST_OUT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (stop_reg)
                        out_data_next = '0;
                    else
                        out_data_next = {ddws_pkg::drive_of(r_acc_reg),
                                         ddws_pkg::drive_of(l_acc_reg)};
                    state_next = ddws_pkg::ST_IDLE;
                end
            end
            default:
                state_next = ddws_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddws_pkg::ST_IDLE;
            stop_reg      <= 1'b0;
            kin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            l_prev_reg    <= '0;
            r_prev_reg    <= '0;
            l_acc_reg     <= '0;
            r_acc_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            stop_reg      <= stop_next;
            kin_reg       <= kin_next;
            out_valid_reg <= out_valid_next;
            l_prev_reg    <= l_prev_next;
            r_prev_reg    <= r_prev_next;
            l_acc_reg     <= l_acc_next;
            r_acc_reg     <= r_acc_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            lc_reg <= $signed(s_tdata[CW-1:0]);
            rc_reg <= $signed(s_tdata[2*CW-1:CW]);
            vx_reg <= $signed(s_tdata[2*CW+SW-1:2*CW]);
            vz_reg <= $signed(s_tdata[2*CW+2*SW-1:2*CW+SW]);
        end
        lm_reg       <= lm_next;
        rm_reg       <= rm_next;
        lt_reg       <= lt_next;
        rt_reg       <= rt_next;
        istep_reg    <= istep_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a stop word skips the whole PI sequence
    a_stop_skips : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && in_stop) |=> (state_reg == ddws_pkg::ST_OUT))
        else $error("stop word did not go straight to output");

    // left loop state moves only in its update step
    a_left_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ddws_pkg::ST_L_ACC) |=> ($stable(l_prev_reg) && $stable(l_acc_reg)))
        else $error("left PI state changed outside its update step");

    // right loop state moves only in its update step
    a_right_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ddws_pkg::ST_R_ACC) |=> ($stable(r_prev_reg) && $stable(r_acc_reg)))
        else $error("right PI state changed outside its update step");

    // a result is never overwritten before it is taken
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending output word was overwritten");

endmodule
